// ===== sv/assert_macros.svh =====
// Assertion macros shared by the servo bus packet engine RTL.
// No dependencies; each module that checks itself includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SBPE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sbpe: assertion failed");
// Condition must never be true outside reset.
`define SBPE_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sbpe: forbidden condition seen");
`else
`define SBPE_ASSERT(label, clk, rst_n, prop)
`define SBPE_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== sv/sbpe_pkg.sv =====
// Types and constants of the servo bus packet engine.
// No dependencies; imported by every module of the block.
package sbpe_pkg;

    localparam logic [2:0] CMD_PING       = 3'd0;
    localparam logic [2:0] CMD_ACTION     = 3'd1;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
    localparam logic [2:0] CMD_WRITE_WORD = 3'd3;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd4;
    localparam logic [2:0] CMD_READ_WORD  = 3'd5;
    localparam logic [2:0] CMD_RX_BYTE    = 3'd6;
    localparam logic [2:0] CMD_TICK       = 3'd7;

    localparam logic [1:0] REG_PING   = 2'd0;
    localparam logic [1:0] REG_ACTION = 2'd1;
    localparam logic [1:0] REG_WRITE  = 2'd2;
    localparam logic [1:0] REG_READ   = 2'd3;

    localparam logic [7:0] PING_OP_RST   = 8'd1;
    localparam logic [7:0] ACTION_OP_RST = 8'd5;
    localparam logic [7:0] WRITE_OP_RST  = 8'd3;
    localparam logic [7:0] READ_OP_RST   = 8'd2;

    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] REPLY_MARK  = 8'hF5;
    localparam logic [15:0] ERR_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ECHO  = 2'd1,
        PH_REPLY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PING  = 2'd0,
        KIND_RBYTE = 2'd1,
        KIND_RWORD = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  servo_id;
        logic [7:0]  reg_address;
        logic [15:0] write_data;
        logic [7:0]  line_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        last;
        logic        resp_done;
        logic        resp_ok;
        logic [15:0] resp_value;
        logic [15:0] errors_seen;
    } t_out;

    typedef struct packed {
        logic [7:0] ping_op;
        logic [7:0] action_op;
        logic [7:0] write_op;
        logic [7:0] read_op;
    } t_cfg;

    // One unit of work for the transmit side: a whole frame or one reply report.
    typedef struct packed {
        logic            is_reply;
        logic [3:0]      last_idx;
        logic [6:0][7:0] body;
        logic            ok;
        logic [15:0]     value;
        logic [15:0]     errors;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== sv/sbpe_front.sv =====
// Front end: accepts items, runs the frame/echo/reply protocol state and
// queues work for the back end. Depends on sbpe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbpe_front
    import sbpe_pkg::*;
#(
    parameter int REPLY_MAX = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_in     i_in_data,
    input  t_cfg    i_cfg,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_work   o_work
);

    localparam int IDX_W = (REPLY_MAX > 1) ? $clog2(REPLY_MAX) : 1;
    localparam logic [4:0] RMAX = 5'(REPLY_MAX);

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [3:0]  r_echo, n_echo;
    logic [3:0]  r_expected, n_expected;
    logic [3:0]  r_count, n_count;
    logic [3:0]  r_ticks, n_ticks;
    logic [7:0]  r_pid, n_pid;
    logic [15:0] r_err, n_err;
    logic [7:0]  r_bytes [REPLY_MAX];

    logic        acc;
    logic        rx_reply;
    logic [3:0]  fin_count;
    logic [7:0]  rb [7];
    logic [1:0]  rn;
    logic        fin_ok;
    logic [15:0] fin_value;
    logic [15:0] fin_err;

    // Frame assembly signals.
    logic [1:0]  np;
    logic [7:0]  instr;
    t_kind       cmd_kind;
    logic [7:0]  pl0, pl1, pl2;
    logic [7:0]  len_byte;
    logic [7:0]  sum;
    logic [7:0]  chk;

    assign acc      = i_in_valid && !i_q_stat.full;
    assign rx_reply = acc && (i_in_data.cmd == CMD_RX_BYTE) && (r_phase == PH_REPLY);

    // Frame contents for the six command codes.
    always_comb begin
        np       = 2'd0;
        instr    = i_cfg.ping_op;
        cmd_kind = KIND_PING;
        pl0      = 8'h00;
        pl1      = 8'h00;
        pl2      = 8'h00;
        unique case (i_in_data.cmd)
            CMD_PING: begin
                instr = i_cfg.ping_op;
            end
            CMD_ACTION: begin
                instr    = i_cfg.action_op;
                cmd_kind = KIND_NONE;
            end
            CMD_WRITE_BYTE: begin
                instr    = i_cfg.write_op;
                cmd_kind = KIND_NONE;
                np       = 2'd2;
                pl0      = i_in_data.reg_address;
                pl1      = i_in_data.write_data[7:0];
            end
            CMD_WRITE_WORD: begin
                instr    = i_cfg.write_op;
                cmd_kind = KIND_NONE;
                np       = 2'd3;
                pl0      = i_in_data.reg_address;
                pl1      = i_in_data.write_data[15:8];
                pl2      = i_in_data.write_data[7:0];
            end
            CMD_READ_BYTE: begin
                instr    = i_cfg.read_op;
                cmd_kind = KIND_RBYTE;
                np       = 2'd2;
                pl0      = i_in_data.reg_address;
                pl1      = 8'd1;
            end
            CMD_READ_WORD: begin
                instr    = i_cfg.read_op;
                cmd_kind = KIND_RWORD;
                np       = 2'd2;
                pl0      = i_in_data.reg_address;
                pl1      = 8'd2;
            end
            CMD_RX_BYTE, CMD_TICK: begin
                instr = i_cfg.ping_op;
            end
            default: begin
                instr = i_cfg.ping_op;
            end
        endcase
    end

    assign len_byte = 8'(np) + 8'd2;
    assign sum      = i_in_data.servo_id + len_byte + instr + pl0 + pl1 + pl2;
    assign chk      = ~sum;

    // Reply bytes as seen after this item, including one arriving now.
    assign fin_count = rx_reply ? (r_count + 4'd1) : r_count;

    for (genvar g = 0; g < 7; g++) begin : g_rb
        if (g < REPLY_MAX) begin : g_stored
            assign rb[g] = (4'(g) >= fin_count) ? 8'h00 :
                           (rx_reply && (r_count == 4'(g))) ? i_in_data.line_byte :
                           r_bytes[g];
        end else begin : g_absent
            assign rb[g] = 8'h00;
        end
    end

    assign rn = (r_kind == KIND_RWORD) ? 2'd2 : ((r_kind == KIND_RBYTE) ? 2'd1 : 2'd0);

    assign fin_ok = (fin_count == r_expected) && (rb[0] == HDR_BYTE) &&
                    (rb[1] == REPLY_MARK) && (rb[2] == r_pid) &&
                    (rb[3] == (8'(rn) + 8'd2));

    always_comb begin
        fin_value = 16'h0000;
        if (fin_ok) begin
            case (r_kind)
                KIND_PING:  fin_value = {8'h00, rb[4]};
                KIND_RBYTE: fin_value = {8'h00, rb[5]};
                default:    fin_value = {rb[5], rb[6]};
            endcase
        end
    end

    assign fin_err = (!fin_ok && (r_err != ERR_MAX)) ? (r_err + 16'd1) : r_err;

    // Protocol state and work generation.
    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_echo     = r_echo;
        n_expected = r_expected;
        n_count    = r_count;
        n_ticks    = r_ticks;
        n_pid      = r_pid;
        n_err      = r_err;
        o_push     = 1'b0;
        o_work     = '0;
        if (acc) begin
            unique case (i_in_data.cmd)
                CMD_PING, CMD_ACTION, CMD_WRITE_BYTE, CMD_WRITE_WORD,
                CMD_READ_BYTE, CMD_READ_WORD: begin
                    if (r_phase == PH_IDLE) begin
                        o_push          = 1'b1;
                        o_work.is_reply = 1'b0;
                        o_work.last_idx = 4'd5 + 4'(np);
                        o_work.body[0]  = i_in_data.servo_id;
                        o_work.body[1]  = len_byte;
                        o_work.body[2]  = instr;
                        o_work.body[3]  = (np == 2'd0) ? chk : pl0;
                        o_work.body[4]  = pl1;
                        o_work.body[5]  = (np == 2'd2) ? chk : pl2;
                        o_work.body[6]  = chk;
                        o_work.errors   = r_err;
                        n_phase = PH_ECHO;
                        n_echo  = 4'd6 + 4'(np);
                        n_pid   = i_in_data.servo_id;
                        n_kind  = cmd_kind;
                    end
                end
                CMD_RX_BYTE: begin
                    if (r_phase == PH_ECHO) begin
                        n_echo = r_echo - 4'd1;
                        if (r_echo == 4'd1) begin
                            if (r_kind == KIND_NONE) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase    = PH_REPLY;
                                n_expected = (r_kind == KIND_RWORD) ? 4'd8 :
                                             ((r_kind == KIND_RBYTE) ? 4'd7 : 4'd6);
                                n_count    = 4'd0;
                                n_ticks    = 4'd0;
                            end
                        end
                    end else if (r_phase == PH_REPLY) begin
                        n_count = fin_count;
                        if (fin_count >= r_expected) begin
                            n_phase = PH_IDLE;
                            n_err   = fin_err;
                            o_push  = 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_phase == PH_REPLY) begin
                        n_ticks = r_ticks + 4'd1;
                        if ((r_ticks + 4'd1) >= r_expected) begin
                            n_phase = PH_IDLE;
                            n_err   = fin_err;
                            o_push  = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            if (o_push && (n_phase == PH_IDLE) && (r_phase == PH_REPLY)) begin
                o_work.is_reply = 1'b1;
                o_work.ok       = fin_ok;
                o_work.value    = fin_value;
                o_work.errors   = fin_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_kind     <= KIND_PING;
            r_echo     <= 4'd0;
            r_expected <= 4'd0;
            r_count    <= 4'd0;
            r_ticks    <= 4'd0;
            r_pid      <= 8'h00;
            r_err      <= 16'h0000;
        end else begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_echo     <= n_echo;
            r_expected <= n_expected;
            r_count    <= n_count;
            r_ticks    <= n_ticks;
            r_pid      <= n_pid;
            r_err      <= n_err;
        end
    end

    // Reply storage; entries at or beyond the byte count read as zero.
    always_ff @(posedge i_clk) begin
        if (rx_reply && ({1'b0, r_count} < RMAX)) begin
            r_bytes[r_count[IDX_W-1:0]] <= i_in_data.line_byte;
        end
    end

    `SBPE_ASSERT(a_reply_has_kind, i_clk, i_rst_n, (r_phase == PH_REPLY) |-> (r_kind != KIND_NONE))
    `SBPE_ASSERT(a_reply_bounds, i_clk, i_rst_n, (r_phase == PH_REPLY) |-> ((r_ticks < r_expected) && (r_count < r_expected)))
    `SBPE_ASSERT(a_echo_pending, i_clk, i_rst_n, (r_phase == PH_ECHO) |-> (r_echo != 4'd0))
    `SBPE_NEVER(a_push_full, i_clk, i_rst_n, o_push && i_q_stat.full)

endmodule

// ===== sv/sbpe_queue.sv =====
// Short work queue between the front and back ends of the packet engine.
// Depends on sbpe_pkg.
module sbpe_queue
    import sbpe_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_work   i_work,
    input  logic    i_pop,
    output t_work   o_head,
    output t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_work         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : (r_wr + PW'(1));
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : (r_rd + PW'(1));
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

// ===== sv/sbpe_back.sv =====
// Back end: expands queued work into result items, one per cycle while the output
// is not stalled, through an output register. Depends on sbpe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbpe_back
    import sbpe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_work   i_head,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_out_valid,
    output t_out    o_out_data,
    input  logic    i_out_stall
);

    logic       r_valid;
    t_out       r_data, n_data;
    logic [3:0] r_idx;
    logic       ld;
    logic       has;
    logic [2:0] bsel;

    assign ld   = !r_valid || !i_out_stall;
    assign has  = !i_q_stat.empty;
    assign bsel = 3'(r_idx - 4'd2);

    always_comb begin
        n_data             = '0;
        n_data.errors_seen = i_head.errors;
        if (i_head.is_reply) begin
            n_data.last       = 1'b1;
            n_data.resp_done  = 1'b1;
            n_data.resp_ok    = i_head.ok;
            n_data.resp_value = i_head.value;
        end else begin
            n_data.tx_valid = 1'b1;
            n_data.tx_byte  = (r_idx < 4'd2) ? HDR_BYTE : i_head.body[bsel];
            n_data.last     = (r_idx == i_head.last_idx);
        end
    end

    assign o_pop = ld && has && (i_head.is_reply || (r_idx == i_head.last_idx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else if (ld) begin
            r_valid <= has;
            if (o_pop) begin
                r_idx <= 4'd0;
            end else if (has) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld && has) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    `SBPE_ASSERT(a_idx_in_frame, i_clk, i_rst_n, (r_idx != 4'd0) |-> (has && !i_head.is_reply && (r_idx <= i_head.last_idx)))

endmodule

// ===== sv/servo_bus_packet_engine_top.sv =====
// The first result of an item passes through the work queue and the back end's output register.
// Throughput: a command yields 6 to 9 frame bytes, one per cycle from the back end unless
// the output stalls; rx byte and tick items are taken one per cycle while the 2-entry
// work queue has room. A reply report is a single result item at the back end.
// Reset: i_rst_n is synchronous, active low; it clears all control state and
// restores the opcode registers to ping 1, action 5, write 3, read 2.
//
// Holds the APB opcode registers and joins the front end, work queue and back end.
// Depends on sbpe_pkg, sbpe_front, sbpe_queue and sbpe_back.
module servo_bus_packet_engine_top
    import sbpe_pkg::*;
#(
    parameter int REPLY_MAX   = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    // Result items.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The four opcode registers sit at byte addresses 0, 4, 8 and 12. The user
    // must change them only while the engine is idle; the block does not enforce
    // this. The front end reads them directly when it frames a command.
    t_cfg    r_cfg;
    t_work   front_work;
    t_work   q_head;
    t_q_stat q_stat;
    logic    front_push;
    logic    back_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ping_op   <= PING_OP_RST;
            r_cfg.action_op <= ACTION_OP_RST;
            r_cfg.write_op  <= WRITE_OP_RST;
            r_cfg.read_op   <= READ_OP_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_PING:   r_cfg.ping_op   <= pwdata[7:0];
                REG_ACTION: r_cfg.action_op <= pwdata[7:0];
                REG_WRITE:  r_cfg.write_op  <= pwdata[7:0];
                REG_READ:   r_cfg.read_op   <= pwdata[7:0];
                default:    r_cfg.ping_op   <= r_cfg.ping_op;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PING:   prdata = {24'h0, r_cfg.ping_op};
            REG_ACTION: prdata = {24'h0, r_cfg.action_op};
            REG_WRITE:  prdata = {24'h0, r_cfg.write_op};
            REG_READ:   prdata = {24'h0, r_cfg.read_op};
            default:    prdata = 32'h0;
        endcase
    end

    // The front end takes an item whenever the work queue has room, so an
    // item is held off only while the queue is full of work the back end has not yet drained.
    assign o_in_stall = q_stat.full;

    // Front end: tracks idle, echo and reply phases, frames commands,
    // counts off the echo, gathers and judges replies, and keeps the
    // saturating error count. Each item that yields results pushes one
    // entry of work.
    sbpe_front #(
        .REPLY_MAX (REPLY_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_stat   (q_stat),
        .o_push     (front_push),
        .o_work     (front_work)
    );

    // The queue lets a new command be framed while the previous frame is
    // still going out, and absorbs stalls on the result side.
    sbpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_work  (front_work),
        .i_pop   (back_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // Back end: walks each frame one byte per cycle into the output
    // register while the output is not stalled, or emits the single reply report.
    sbpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_stat    (q_stat),
        .o_pop       (back_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for servo_bus_packet_engine_top: frames, echo and reply handling.
// Depends on sbpe_pkg and the RTL of the block; it predicts every result on its own.
`timescale 1ns / 100ps

module testbench;
    import sbpe_pkg::*;

    localparam int REPLY_SLOTS = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    servo_bus_packet_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // Items waiting to be sent, and the bus results the engine still owes us.
    t_in  feed_q[$];
    t_out results_due[$];

    int mismatches = 0;
    int items_queued = 0;
    int taken = 0;
    int delivered = 0;
    bit quiet = 1'b0;
    int in_gap_pct = 30;
    int out_gap_pct = 30;
    int in_gap_left = 0;
    int out_stall_left = 0;

    // Our own copy of the engine state and of the opcode registers.
    t_phase     eng_phase = PH_IDLE;
    t_kind      eng_kind = KIND_PING;
    int         echo_left = 0;
    int         reply_len = 0;
    int         reply_cnt = 0;
    int         ticks_seen = 0;
    logic [7:0] pend_id = '0;
    logic [7:0] reply_buf [REPLY_SLOTS];
    logic [15:0] err_cnt = '0;
    t_cfg       op_regs = '{ping_op: PING_OP_RST, action_op: ACTION_OP_RST,
                            write_op: WRITE_OP_RST, read_op: READ_OP_RST};

    initial begin
        foreach (reply_buf[i]) reply_buf[i] = '0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // The reply is judged on count, header, id and length byte; a failure bumps
    // the saturating error count.
    task automatic finish_reply();
        t_out r;
        int   n;
        logic ok;
        n = (eng_kind == KIND_RWORD) ? 2 : (eng_kind == KIND_RBYTE) ? 1 : 0;
        ok = (reply_cnt == reply_len) && reply_buf[0] == HDR_BYTE &&
             reply_buf[1] == REPLY_MARK && reply_buf[2] == pend_id &&
             reply_buf[3] == 8'(n + 2);
        r = '0;
        r.last = 1'b1;
        r.resp_done = 1'b1;
        r.resp_ok = ok;
        if (ok) begin
            case (eng_kind)
                KIND_PING:  r.resp_value = {8'h00, reply_buf[4]};
                KIND_RBYTE: r.resp_value = {8'h00, reply_buf[5]};
                default:    r.resp_value = {reply_buf[5], reply_buf[6]};
            endcase
        end else if (err_cnt != ERR_MAX) begin
            err_cnt++;
        end
        r.errors_seen = err_cnt;
        eng_phase = PH_IDLE;
        results_due.push_back(r);
    endtask

    task automatic advance_engine(input t_in it);
        logic [7:0] fr [9];
        logic [7:0] instr;
        logic [7:0] sum;
        int   np;
        int   len;
        t_out r;
        if (it.cmd <= CMD_READ_WORD) begin
            // Commands are dropped unless the engine is idle.
            if (eng_phase != PH_IDLE) return;
            np = 0;
            case (it.cmd)
                CMD_PING: begin
                    instr = op_regs.ping_op;
                    eng_kind = KIND_PING;
                end
                CMD_ACTION: begin
                    instr = op_regs.action_op;
                    eng_kind = KIND_NONE;
                end
                CMD_WRITE_BYTE: begin
                    instr = op_regs.write_op;
                    eng_kind = KIND_NONE;
                    fr[5] = it.reg_address;
                    fr[6] = it.write_data[7:0];
                    np = 2;
                end
                CMD_WRITE_WORD: begin
                    instr = op_regs.write_op;
                    eng_kind = KIND_NONE;
                    fr[5] = it.reg_address;
                    fr[6] = it.write_data[15:8];
                    fr[7] = it.write_data[7:0];
                    np = 3;
                end
                CMD_READ_BYTE: begin
                    instr = op_regs.read_op;
                    eng_kind = KIND_RBYTE;
                    fr[5] = it.reg_address;
                    fr[6] = 8'd1;
                    np = 2;
                end
                default: begin
                    instr = op_regs.read_op;
                    eng_kind = KIND_RWORD;
                    fr[5] = it.reg_address;
                    fr[6] = 8'd2;
                    np = 2;
                end
            endcase
            fr[0] = HDR_BYTE;
            fr[1] = HDR_BYTE;
            fr[2] = it.servo_id;
            fr[3] = 8'(np + 2);
            fr[4] = instr;
            sum = '0;
            for (int i = 2; i < 5 + np; i++) sum += fr[i];
            len = 6 + np;
            fr[len - 1] = ~sum;
            pend_id = it.servo_id;
            echo_left = len;
            eng_phase = PH_ECHO;
            for (int i = 0; i < len; i++) begin
                r = '0;
                r.tx_byte = fr[i];
                r.tx_valid = 1'b1;
                r.last = (i == len - 1);
                r.errors_seen = err_cnt;
                results_due.push_back(r);
            end
        end else if (it.cmd == CMD_RX_BYTE) begin
            if (eng_phase == PH_ECHO) begin
                if (echo_left > 0) echo_left--;
                if (echo_left == 0) begin
                    if (eng_kind == KIND_NONE) begin
                        eng_phase = PH_IDLE;
                    end else begin
                        eng_phase = PH_REPLY;
                        reply_len = 6 + ((eng_kind == KIND_RWORD) ? 2 :
                                         (eng_kind == KIND_RBYTE) ? 1 : 0);
                        reply_cnt = 0;
                        ticks_seen = 0;
                        foreach (reply_buf[i]) reply_buf[i] = '0;
                    end
                end
            end else if (eng_phase == PH_REPLY) begin
                if (reply_cnt < REPLY_SLOTS) reply_buf[reply_cnt] = it.line_byte;
                reply_cnt++;
                if (reply_cnt >= reply_len) finish_reply();
            end
        end else if (eng_phase == PH_REPLY) begin
            ticks_seen++;
            if (ticks_seen >= reply_len) finish_reply();
        end
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (results_due.size() == 0) begin
            report_mismatch("result with none expected, tx_byte", 16'(got.tx_byte), 16'h0000);
            return;
        end
        want = results_due.pop_front();
        if (got.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
        if (got.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", 16'(got.tx_valid), 16'(want.tx_valid));
        if (got.last !== want.last)
            report_mismatch("last", 16'(got.last), 16'(want.last));
        if (got.resp_done !== want.resp_done)
            report_mismatch("resp_done", 16'(got.resp_done), 16'(want.resp_done));
        if (got.resp_ok !== want.resp_ok)
            report_mismatch("resp_ok", 16'(got.resp_ok), 16'(want.resp_ok));
        if (got.resp_value !== want.resp_value)
            report_mismatch("resp_value", got.resp_value, want.resp_value);
        if (got.errors_seen !== want.errors_seen)
            report_mismatch("errors_seen", got.errors_seen, want.errors_seen);
    endtask

    // Driver: an item is taken at an edge with valid high and stall low. A new
    // item, or a gap with valid low, follows only once the current one is gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_engine(i_in_data);
                taken++;
                if (taken % 50 == 0)
                    in_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (!quiet && feed_q.size() != 0 &&
                             $urandom_range(0, 99) < in_gap_pct) begin
                    in_gap_left = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (feed_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= feed_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result taken, then decides the stall for the next edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_result(o_out_data);
                delivered++;
                if (delivered % 40 == 0)
                    out_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            end
            if (out_stall_left > 0) begin
                out_stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < out_gap_pct) begin
                out_stall_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in rand_item(input logic [2:0] cmd);
        t_in it;
        it.cmd = cmd;
        it.servo_id = 8'($urandom_range(0, 255));
        it.reg_address = 8'($urandom_range(0, 255));
        it.write_data = 16'($urandom_range(0, 65535));
        it.line_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic feed(input t_in it);
        feed_q.push_back(it);
        items_queued++;
    endtask

    task automatic feed_rx(input logic [7:0] b);
        t_in it;
        it = rand_item(CMD_RX_BYTE);
        it.line_byte = b;
        feed(it);
    endtask

    function automatic int frame_len(input logic [2:0] cmd);
        case (cmd)
            CMD_PING, CMD_ACTION:          return 6;
            CMD_WRITE_WORD:                return 9;
            default:                       return 8;
        endcase
    endfunction

    function automatic int reply_len_of(input logic [2:0] cmd);
        case (cmd)
            CMD_PING:      return 6;
            CMD_READ_BYTE: return 7;
            CMD_READ_WORD: return 8;
            default:       return 0;
        endcase
    endfunction

    // Nine bus bytes and eight ticks bring the engine back to idle from any state.
    task automatic feed_resync();
        repeat (9) feed_rx(8'($urandom_range(0, 255)));
        repeat (8) feed(rand_item(CMD_TICK));
    endtask

    // One command with its echo and, for pings and reads, a reply that is good,
    // carries a corrupted byte among its first four, or stops short and runs into the timeout.
    task automatic feed_exchange();
        t_in        c;
        logic [7:0] reply [8];
        int         n_reply;
        int         mode;
        int         cut;
        int         ticks_left;
        c = rand_item(3'($urandom_range(0, 5)));
        if ($urandom_range(0, 7) == 0) c.servo_id = 8'hFE;
        feed(c);
        for (int i = 0; i < frame_len(c.cmd); i++) begin
            if ($urandom_range(0, 9) == 0) feed(rand_item(CMD_TICK));
            if ($urandom_range(0, 19) == 0) feed(rand_item(3'($urandom_range(0, 5))));
            feed_rx(8'($urandom_range(0, 255)));
        end
        n_reply = reply_len_of(c.cmd);
        if (n_reply == 0) return;
        foreach (reply[i]) reply[i] = 8'($urandom_range(0, 255));
        reply[0] = HDR_BYTE;
        reply[1] = REPLY_MARK;
        reply[2] = c.servo_id;
        reply[3] = 8'(n_reply - 4);
        mode = $urandom_range(0, 9);
        if (mode == 7 || mode == 8)
            reply[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        cut = (mode == 9) ? $urandom_range(0, n_reply - 1) : n_reply;
        ticks_left = (mode == 9) ? 0 : $urandom_range(0, n_reply - 1);
        for (int i = 0; i < cut; i++) begin
            if (ticks_left > 0 && $urandom_range(0, 2) == 0) begin
                feed(rand_item(CMD_TICK));
                ticks_left--;
            end
            feed_rx(reply[i]);
        end
        if (mode == 9) repeat (n_reply) feed(rand_item(CMD_TICK));
    endtask

    task automatic feed_noise();
        repeat ($urandom_range(1, 6)) feed(rand_item(3'($urandom_range(0, 7))));
        feed_resync();
    endtask

    // Bus byte and tick while idle, a broadcast ping with a command arriving
    // during its echo and a good reply, then a word write at the field extremes.
    task automatic feed_directed();
        t_in it;
        feed_rx(8'hA5);
        feed(rand_item(CMD_TICK));
        it = rand_item(CMD_PING);
        it.servo_id = 8'hFE;
        feed(it);
        repeat (3) feed_rx(8'($urandom_range(0, 255)));
        feed(rand_item(CMD_WRITE_WORD));
        repeat (3) feed_rx(8'($urandom_range(0, 255)));
        feed_rx(HDR_BYTE);
        feed_rx(REPLY_MARK);
        feed_rx(8'hFE);
        feed_rx(8'h02);
        feed_rx(8'h80);
        feed_rx(8'h00);
        it = rand_item(CMD_WRITE_WORD);
        it.servo_id = 8'h00;
        it.reg_address = 8'hFF;
        it.write_data = 16'hFFFF;
        feed(it);
        repeat (9) feed_rx(8'($urandom_range(0, 255)));
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_opcodes(input t_cfg s);
        apb_write(REG_PING, s.ping_op);
        apb_write(REG_ACTION, s.action_op);
        apb_write(REG_WRITE, s.write_op);
        apb_write(REG_READ, s.read_op);
        op_regs = s;
    endtask

    // Waits until every item is sent and every result has come back, then lets
    // the engine finish items that produce no result.
    task automatic drain();
        while (feed_q.size() != 0 || i_in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        t_cfg setting;
        int   goal;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        feed_directed();
        drain();
        // Opcode settings: all zero, all ones, then two random ones. The last
        // stretch runs without any gaps or stalls.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       setting = '0;
                1:       setting = '1;
                default: setting = t_cfg'($urandom);
            endcase
            load_opcodes(setting);
            quiet = (p == 3);
            goal = items_queued + 90;
            while (items_queued < goal) begin
                if ($urandom_range(0, 4) != 0) feed_exchange();
                else feed_noise();
            end
            drain();
        end
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
